// ===== rtl/spdol_pkg.sv =====
// Types, codes and saturation helper shared by the setpoint differentiator.
`default_nettype none

package spdol_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned LIMIT_W = 31;

    typedef enum logic [1:0] {
        KIND_SETPOINT = 2'd0,
        KIND_IDLE     = 2'd1,
        KIND_PRESET   = 2'd2
    } kind_t;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [POS_W:0]   wide_t;

    typedef struct packed {
        kind_t kind;
        pos_t  cmd_pos;
    } cmd_t;

    typedef struct packed {
        logic valid_res;
        pos_t step_delta;
        pos_t abs_position;
        pos_t velocity;
        pos_t accel;
        pos_t jerk;
        logic overspeed_now;
        logic overspeed_seen;
    } res_t;

    function automatic pos_t sat33(input wide_t v);
        pos_t r;
        if (v[POS_W] != v[POS_W-1])
        begin
            r = {v[POS_W], {(POS_W-1){~v[POS_W]}}};
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic wide_t sext33(input pos_t v);
        return {v[POS_W-1], v};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spdol_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none

interface spdol_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/spdol_diff_stage.sv =====
// Pipeline stage that differences an operand against its last setpoint value.
`default_nettype none

module spdol_diff_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spdol_pkg::res_t   in_data,
    input  wire spdol_pkg::pos_t   in_operand,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spdol_pkg::res_t        out_data,
    output spdol_pkg::pos_t        out_diff
);

    logic            valid_reg;
    logic            valid_next;
    spdol_pkg::res_t data_reg;
    spdol_pkg::pos_t diff_reg;
    spdol_pkg::pos_t diff_next;
    spdol_pkg::pos_t prev_reg;
    spdol_pkg::pos_t prev_next;
    logic            take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        prev_next  = prev_reg;
        diff_next  = '0;
        if (in_data.valid_res)
        begin
            diff_next = spdol_pkg::sat33(spdol_pkg::sext33(in_operand)
                                         - spdol_pkg::sext33(prev_reg));
        end
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        if (take && in_data.valid_res)
        begin
            prev_next = in_operand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            prev_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= in_data;
            diff_reg <= diff_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_diff  = diff_reg;

endmodule

`default_nettype wire

// ===== rtl/setpoint_differentiator_overspeed_lock.sv =====
// Top level: overspeed check, position lock and three-stage differencing pipeline.
//
//   channel  dir  payload        transaction
//   cmd      in   spdol cmd_t    cmd.valid && cmd.ready
//   res      out  spdol res_t    res.valid && res.ready
//   cfg      in   31-bit limit   cfg_wr_en high
//
// Lock, accel and jerk stages are registered; one command per cycle unless res stalls.
// Lock stage, acceleration stage and jerk stage each hold their own history register.
// A stall on res fills the stages in turn; cmd.ready falls only when all three are full.
// Reset clears all history, the limit and the sticky overspeed flag.
`default_nettype none

module setpoint_differentiator_overspeed_lock (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    spdol_stream_if.sink                           cmd,
    spdol_stream_if.source                         res,
    input  wire logic                              cfg_wr_en,
    input  wire logic [spdol_pkg::LIMIT_W-1:0]     cfg_wr_data
);

    localparam spdol_pkg::pos_t POS_MAX = {1'b0, {(spdol_pkg::POS_W-1){1'b1}}};
    localparam spdol_pkg::pos_t POS_MIN = {1'b1, {(spdol_pkg::POS_W-1){1'b0}}};

    logic [spdol_pkg::LIMIT_W-1:0] limit_reg;
    spdol_pkg::pos_t               last_pos_reg;
    spdol_pkg::pos_t               last_pos_next;
    spdol_pkg::pos_t               last_inc_reg;
    spdol_pkg::pos_t               last_inc_next;
    logic                          sticky_reg;
    logic                          sticky_next;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    spdol_pkg::res_t               s1_data_reg;
    spdol_pkg::res_t               s1_data_next;

    logic                          take;
    logic                          s2_in_ready;
    spdol_pkg::wide_t              d_up;
    spdol_pkg::wide_t              d_dn;
    spdol_pkg::wide_t              lim_w;
    spdol_pkg::wide_t              lock_sum;
    spdol_pkg::wide_t              to_max;
    spdol_pkg::wide_t              to_min;
    logic                          over;
    spdol_pkg::pos_t               lock_pos;
    spdol_pkg::pos_t               lock_dlt;
    spdol_pkg::pos_t               sp_pos;
    spdol_pkg::pos_t               sp_dlt;

    logic                          s2_valid;
    logic                          s3_in_ready;
    spdol_pkg::res_t               s2_data;
    spdol_pkg::pos_t               s2_diff;
    spdol_pkg::res_t               s2_full;
    spdol_pkg::res_t               s3_data;
    spdol_pkg::pos_t               s3_diff;

    assign cmd.ready = !s1_valid_reg || s2_in_ready;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        d_up     = spdol_pkg::sext33(cmd.payload.cmd_pos) - spdol_pkg::sext33(last_pos_reg);
        d_dn     = spdol_pkg::sext33(last_pos_reg) - spdol_pkg::sext33(cmd.payload.cmd_pos);
        lim_w    = {2'b00, limit_reg};
        over     = (d_up > lim_w) || (d_dn > lim_w);
        lock_sum = spdol_pkg::sext33(last_pos_reg) + spdol_pkg::sext33(last_inc_reg);
        to_max   = spdol_pkg::sext33(POS_MAX) - spdol_pkg::sext33(last_pos_reg);
        to_min   = spdol_pkg::sext33(POS_MIN) - spdol_pkg::sext33(last_pos_reg);
        lock_pos = spdol_pkg::sat33(lock_sum);
        if (lock_sum[spdol_pkg::POS_W] != lock_sum[spdol_pkg::POS_W-1])
        begin
            lock_dlt = lock_sum[spdol_pkg::POS_W] ? to_min[spdol_pkg::POS_W-1:0]
                                                  : to_max[spdol_pkg::POS_W-1:0];
        end
        else
        begin
            lock_dlt = last_inc_reg;
        end
        sp_pos = over ? lock_pos : cmd.payload.cmd_pos;
        sp_dlt = over ? lock_dlt : spdol_pkg::sat33(d_up);
    end

    always_comb
    begin
        last_pos_next = last_pos_reg;
        last_inc_next = last_inc_reg;
        sticky_next   = sticky_reg;
        s1_valid_next = s1_valid_reg;
        s1_data_next  = '0;
        s1_data_next.abs_position = last_pos_reg;
        unique case (cmd.payload.kind)
            spdol_pkg::KIND_SETPOINT:
            begin
                s1_data_next.valid_res     = 1'b1;
                s1_data_next.step_delta    = sp_dlt;
                s1_data_next.velocity      = sp_dlt;
                s1_data_next.abs_position  = sp_pos;
                s1_data_next.overspeed_now = over;
                if (take)
                begin
                    last_pos_next = sp_pos;
                    last_inc_next = sp_dlt;
                    sticky_next   = sticky_reg || over;
                end
            end
            spdol_pkg::KIND_PRESET:
            begin
                s1_data_next.abs_position = cmd.payload.cmd_pos;
                if (take)
                begin
                    last_pos_next = cmd.payload.cmd_pos;
                end
            end
            default:
            begin
                if (take)
                begin
                    last_inc_next = '0;
                end
            end
        endcase
        s1_data_next.overspeed_seen = sticky_reg || s1_data_next.overspeed_now;
        if (cmd.ready)
        begin
            s1_valid_next = cmd.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= '0;
            last_pos_reg <= '0;
            last_inc_reg <= '0;
            sticky_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            last_pos_reg <= last_pos_next;
            last_inc_reg <= last_inc_next;
            sticky_reg   <= sticky_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_data_reg <= s1_data_next;
        end
    end

    spdol_diff_stage u_accel_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_ready   (s2_in_ready),
        .in_data    (s1_data_reg),
        .in_operand (s1_data_reg.velocity),
        .out_valid  (s2_valid),
        .out_ready  (s3_in_ready),
        .out_data   (s2_data),
        .out_diff   (s2_diff)
    );

    always_comb
    begin
        s2_full       = s2_data;
        s2_full.accel = s2_diff;
    end

    spdol_diff_stage u_jerk_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s3_in_ready),
        .in_data    (s2_full),
        .in_operand (s2_full.accel),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .out_data   (s3_data),
        .out_diff   (s3_diff)
    );

    always_comb
    begin
        res.payload      = s3_data;
        res.payload.jerk = s3_diff;
    end

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.payload.valid_res) |->
            (res.payload.step_delta == '0 && res.payload.accel == '0 &&
             res.payload.jerk == '0 && !res.payload.overspeed_now))
        else $error("non-setpoint result carries nonzero derivatives");

    a_now_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.payload.overspeed_now) |-> res.payload.overspeed_seen)
        else $error("overspeed result without sticky flag");

    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(sticky_reg))
        else $error("sticky overspeed flag cleared outside reset");

    a_vel_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.payload.velocity == res.payload.step_delta))
        else $error("velocity differs from step delta");

    a_over_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.payload.kind == spdol_pkg::KIND_SETPOINT && over) |=>
            (last_pos_reg == $past(lock_pos) && sticky_reg))
        else $error("overspeed setpoint not replaced by locked position");

endmodule

`default_nettype wire

// ===== test/setpoint_differentiator_overspeed_lock_tb.sv =====
// Self-checking testbench for the setpoint differentiator with overspeed lock.
module setpoint_differentiator_overspeed_lock_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 236;

    typedef struct {
        spdol_pkg::cmd_t cmd;
        bit              hold;
    } queued_cmd_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [spdol_pkg::LIMIT_W-1:0] cfg_wr_data;

    spdol_stream_if #(.payload_t(spdol_pkg::cmd_t)) cmd_ch ();
    spdol_stream_if #(.payload_t(spdol_pkg::res_t)) res_ch ();

    setpoint_differentiator_overspeed_lock uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    queued_cmd_t cmd_backlog[$];
    spdol_pkg::res_t motion_expected[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit cmd_took = 1'b0;

    logic [spdol_pkg::LIMIT_W-1:0] lim_model;
    spdol_pkg::pos_t pos_model;
    spdol_pkg::pos_t inc_model;
    spdol_pkg::pos_t vel_model;
    spdol_pkg::pos_t acc_model;
    logic sticky_model;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic spdol_pkg::pos_t clamp32(input longint v);
        spdol_pkg::pos_t r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = spdol_pkg::pos_t'(v);
        end
        return r;
    endfunction

    task automatic predict_motion(input spdol_pkg::cmd_t c);
        spdol_pkg::res_t r;
        longint diff;
        longint mag;
        spdol_pkg::pos_t target;
        r = '0;
        target = c.cmd_pos;
        if (c.kind == spdol_pkg::KIND_SETPOINT)
        begin
            diff = longint'(target) - longint'(pos_model);
            mag = (diff < 0) ? -diff : diff;
            if (mag > longint'({33'd0, lim_model}))
            begin
                target = clamp32(longint'(pos_model) + longint'(inc_model));
                r.overspeed_now = 1'b1;
                sticky_model = 1'b1;
            end
            r.valid_res = 1'b1;
            r.step_delta = clamp32(longint'(target) - longint'(pos_model));
            r.velocity = r.step_delta;
            r.accel = clamp32(longint'(r.step_delta) - longint'(vel_model));
            r.jerk = clamp32(longint'(r.accel) - longint'(acc_model));
            pos_model = target;
            inc_model = r.step_delta;
            vel_model = r.step_delta;
            acc_model = r.accel;
        end
        else if (c.kind == spdol_pkg::KIND_PRESET)
        begin
            pos_model = c.cmd_pos;
        end
        else
        begin
            inc_model = '0;
        end
        r.abs_position = pos_model;
        r.overspeed_seen = sticky_model;
        motion_expected.insert(motion_expected.size(), r);
    endtask

    task automatic report_mismatch(input string what, input spdol_pkg::pos_t got,
                                   input spdol_pkg::pos_t want);
        $display("mismatch in %s at cycle %0d: got %0d, expected %0d",
                 what, cycles, got, want);
        errors++;
    endtask

    task automatic queue_cmd(input spdol_pkg::kind_t k, input spdol_pkg::pos_t p,
                             input bit hold);
        queued_cmd_t q;
        q.cmd.kind = k;
        q.cmd.cmd_pos = p;
        q.hold = hold;
        cmd_backlog.insert(cmd_backlog.size(), q);
    endtask

    task automatic drain_motion();
        while (cmd_backlog.size() != 0 || motion_expected.size() != 0 || cmd_ch.valid)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [spdol_pkg::LIMIT_W-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        spdol_pkg::res_t want;
        spdol_pkg::res_t got;
        if (!rst_n)
        begin
            lim_model = '0;
            pos_model = '0;
            inc_model = '0;
            vel_model = '0;
            acc_model = '0;
            sticky_model = 1'b0;
            cmd_took <= 1'b0;
        end
        else
        begin
            cmd_took <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_motion(cmd_ch.payload);
            end
            if (cfg_wr_en)
            begin
                lim_model = cfg_wr_data;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.payload;
                if (motion_expected.size() == 0)
                begin
                    report_mismatch("result with nothing pending", got.abs_position, '0);
                end
                else
                begin
                    want = motion_expected.pop_front();
                    if (got.valid_res !== want.valid_res)
                        report_mismatch("valid_res", spdol_pkg::pos_t'(got.valid_res),
                                        spdol_pkg::pos_t'(want.valid_res));
                    if (got.step_delta !== want.step_delta)
                        report_mismatch("step_delta", got.step_delta, want.step_delta);
                    if (got.abs_position !== want.abs_position)
                        report_mismatch("abs_position", got.abs_position, want.abs_position);
                    if (got.velocity !== want.velocity)
                        report_mismatch("velocity", got.velocity, want.velocity);
                    if (got.accel !== want.accel)
                        report_mismatch("accel", got.accel, want.accel);
                    if (got.jerk !== want.jerk)
                        report_mismatch("jerk", got.jerk, want.jerk);
                    if (got.overspeed_now !== want.overspeed_now)
                        report_mismatch("overspeed_now", spdol_pkg::pos_t'(got.overspeed_now),
                                        spdol_pkg::pos_t'(want.overspeed_now));
                    if (got.overspeed_seen !== want.overspeed_seen)
                        report_mismatch("overspeed_seen",
                                        spdol_pkg::pos_t'(got.overspeed_seen),
                                        spdol_pkg::pos_t'(want.overspeed_seen));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        queued_cmd_t nxt;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (!cmd_ch.valid || cmd_took)
            begin
                if (cmd_backlog.size() != 0
                    && !(cmd_backlog[0].hold && motion_expected.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = cmd_backlog.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.payload <= nxt.cmd;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        logic [spdol_pkg::LIMIT_W-1:0] phase_lim [6];
        spdol_pkg::pos_t walk;
        logic [31:0] step;
        int unsigned roll;
        int unsigned ph;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        rst_n = 1'b0;
        phase_lim[0] = 31'd1000;
        phase_lim[1] = 31'h7FFF_FFFF;
        phase_lim[2] = 31'd0;
        phase_lim[3] = 31'h0001_0000;
        phase_lim[4] = 31'h3FFF_FFFF;
        phase_lim[5] = 31'd37;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 51;

        // zero limit from reset: any nonzero change locks
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sd0, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sd5, 1'b0);
        queue_cmd(spdol_pkg::KIND_IDLE, 32'sd9, 1'b0);
        queue_cmd(spdol_pkg::KIND_PRESET, 32'sd1000, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sd1000, 1'b0);
        queue_cmd(spdol_pkg::kind_t'(2'd3), 32'sd77, 1'b0);
        drain_motion();

        write_limit(31'h7FFF_FFFF);
        queue_cmd(spdol_pkg::KIND_PRESET, 32'sd0, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sh7FFF_FFFF, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sh8000_0000, 1'b0);
        queue_cmd(spdol_pkg::KIND_PRESET, 32'sh8000_0000, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, -32'sd1, 1'b0);
        queue_cmd(spdol_pkg::KIND_PRESET, 32'sh7FFF_FFFF, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sd0, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, -32'sh7FFF_FFFF, 1'b0);
        queue_cmd(spdol_pkg::KIND_IDLE, 32'sh7FFF_FFFF, 1'b0);
        queue_cmd(spdol_pkg::KIND_PRESET, -32'sd1, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sh8000_0000, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sh7FFF_FFFF, 1'b0);
        drain_motion();

        write_limit(31'd1);
        queue_cmd(spdol_pkg::KIND_PRESET, 32'sd50, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sd51, 1'b1);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sd53, 1'b0);
        queue_cmd(spdol_pkg::KIND_SETPOINT, 32'sd52, 1'b0);
        drain_motion();

        walk = '0;
        for (ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 31;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_limit(phase_lim[ph]);
            @(posedge clk);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    queue_cmd(spdol_pkg::KIND_IDLE, $urandom, $urandom_range(99) == 0);
                end
                else if (roll < 14)
                begin
                    walk = $urandom;
                    queue_cmd(spdol_pkg::KIND_PRESET, walk, $urandom_range(99) == 0);
                end
                else if (roll < 22)
                begin
                    queue_cmd(spdol_pkg::KIND_SETPOINT, $urandom, 1'b0);
                end
                else if (roll < 30)
                begin
                    // land on the limit or one either side of it
                    walk = $urandom;
                    queue_cmd(spdol_pkg::KIND_PRESET, walk, 1'b0);
                    step = {1'b0, phase_lim[ph]} + 32'($urandom_range(2)) - 32'd1;
                    if ($urandom_range(1) == 1)
                    begin
                        step = -step;
                    end
                    walk = walk + step;
                    queue_cmd(spdol_pkg::KIND_SETPOINT, walk, 1'b0);
                end
                else
                begin
                    step = $urandom >> $urandom_range(31, 0);
                    if ($urandom_range(1) == 1)
                    begin
                        step = -step;
                    end
                    walk = walk + step;
                    queue_cmd(spdol_pkg::KIND_SETPOINT, walk, $urandom_range(99) == 0);
                end
            end
            drain_motion();
        end

        repeat (12) @(posedge clk);
        if (errors == 0 && motion_expected.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
